>>> hdl/hsv_to_rgb_converter_unit_defines.svh
// Assertion macros for the HSV to RGB converter checker.
// Depends on nothing; included by hsv2rgb_checker.sv.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

// Property checked outside reset.
`define HSV2RGB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every edge, reset included.
`define HSV2RGB_ASSERT_ALL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/hsv2rgb_pkg.sv
// Types and constants for the HSV to RGB converter.
// Depends on nothing; used by the top level and its checker.
package hsv2rgb_pkg;

   localparam int COLOR_FRAC_BITS = 12;
   localparam int HUE_FRAC_BITS   = 6;
   localparam int HUE_W           = 15;
   localparam int COLOR_W         = 13;
   localparam int REM_W           = 12;
   localparam int SECTOR_W        = 3;
   localparam int NUM_SECTORS     = 6;

   localparam logic [COLOR_W-1:0] COLOR_ONE  = COLOR_W'(1 << COLOR_FRAC_BITS);
   localparam logic [HUE_W-1:0]   HUE_SECTOR = HUE_W'(60 << HUE_FRAC_BITS);
   localparam logic [HUE_W-1:0]   HUE_FULL   = HUE_W'(360 << HUE_FRAC_BITS);

   // ff = (rem << 12) / 3840 = (rem << 4) / 15, done as ((x + 1) * 4369) >> 16
   localparam int FF_PRE_SHIFT = 4;
   localparam int FF_NUM_W     = REM_W + FF_PRE_SHIFT;
   localparam int FF_RECIP_W   = 13;
   localparam logic [FF_RECIP_W-1:0] FF_RECIP = FF_RECIP_W'(4369);
   localparam int FF_SHIFT     = 16;
   localparam int FF_PROD_W    = FF_NUM_W + FF_RECIP_W;
   localparam int FF_W         = COLOR_FRAC_BITS;

   localparam int MUL_W        = 2 * COLOR_W;

   typedef struct packed {
      logic [HUE_W-1:0]   hue;
      logic [COLOR_W-1:0] saturation;
      logic [COLOR_W-1:0] value;
   } hsv_pixel_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_pixel_type;

   typedef enum logic [SECTOR_W-1:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

endpackage

>>> hdl/hsv_to_rgb_converter_unit.sv
// HSV to RGB converter, four register stages, one pixel beat per cycle unless stalled.
// Order: a taken req beat passes stages 1, 2, 3 and 4; rsp_valid is the stage 4 valid bit.
// Throughput: one beat per cycle unless stalled; req_stall only rises with all stages full.
// Reset: synchronous, active high, clears the stage valid bits only.
// Depends on hsv2rgb_pkg.
module hsv_to_rgb_converter_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  hsv2rgb_pkg::hsv_pixel_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output hsv2rgb_pkg::rgb_pixel_type rsp_data
);
   import hsv2rgb_pkg::*;

   // stage valid bits and loads
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic ld1, ld2, ld3, ld4;

   // stage 1: clamp, hue wrap, sector split
   logic [HUE_W-1:0]   h_wrap;
   logic [HUE_W-1:0]   sec_base;
   sector_type         sec_c;
   logic [COLOR_W-1:0] s_c, v_c;
   sector_type         sec1_ff, sec2_ff, sec3_ff, sec4_in;
   logic [REM_W-1:0]   rem1_ff, rem1_in;
   logic [COLOR_W-1:0] s1_ff, v1d_ff, s2_ff, v2d_ff, v3d_ff;
   logic               grey1_ff, grey2_ff, grey3_ff;

   // stage 2: fraction and p
   logic [FF_NUM_W-1:0]  ff_num;
   logic [FF_PROD_W-1:0] ff_prod;
   logic [MUL_W-1:0]     p_prod;
   logic [FF_W-1:0]      ff2_ff, ff2_in;
   logic [COLOR_W-1:0]   p2_ff, p2_in, p3_ff;

   // stage 3: s*ff and s*(1-ff)
   logic [MUL_W-1:0]   sf_prod, sg_prod;
   logic [COLOR_W-1:0] sf3_ff, sf3_in, sg3_ff, sg3_in;

   // stage 4: q, t and routing
   logic [MUL_W-1:0]   q_prod, t_prod;
   logic [COLOR_W-1:0] q_c, t_c;
   rgb_pixel_type      rgb4_ff, rgb4_in;

   always_comb begin
      ld4 = !v4_ff || !rsp_stall;
      ld3 = !v3_ff || ld4;
      ld2 = !v2_ff || ld3;
      ld1 = !v1_ff || ld2;
      req_stall = !ld1;
      v1_in = ld1 ? req_valid : v1_ff;
      v2_in = ld2 ? v1_ff : v2_ff;
      v3_in = ld3 ? v2_ff : v3_ff;
      v4_in = ld4 ? v3_ff : v4_ff;
   end

   always_comb begin
      h_wrap   = (req_data.hue >= HUE_FULL) ? '0 : req_data.hue;
      s_c      = (req_data.saturation > COLOR_ONE) ? COLOR_ONE : req_data.saturation;
      v_c      = (req_data.value > COLOR_ONE) ? COLOR_ONE : req_data.value;
      sec_c    = SECTOR_0;
      sec_base = '0;
      for (int k = 1; k < NUM_SECTORS; k++) begin
         if (h_wrap >= HUE_W'(k * HUE_SECTOR)) begin
            sec_c    = sector_type'(SECTOR_W'(k));
            sec_base = HUE_W'(k * HUE_SECTOR);
         end
      end
      rem1_in = REM_W'(h_wrap - sec_base);
   end

   always_comb begin
      ff_num  = FF_NUM_W'({rem1_ff, {FF_PRE_SHIFT{1'b0}}}) + FF_NUM_W'(1);
      ff_prod = FF_PROD_W'(ff_num) * FF_PROD_W'(FF_RECIP);
      ff2_in  = FF_W'(ff_prod >> FF_SHIFT);
      p_prod  = MUL_W'(v1d_ff) * MUL_W'(COLOR_ONE - s1_ff);
      p2_in   = COLOR_W'(p_prod >> COLOR_FRAC_BITS);
   end

   always_comb begin
      sf_prod = MUL_W'(s2_ff) * MUL_W'(ff2_ff);
      sg_prod = MUL_W'(s2_ff) * MUL_W'(COLOR_ONE - COLOR_W'(ff2_ff));
      sf3_in  = COLOR_W'(sf_prod >> COLOR_FRAC_BITS);
      sg3_in  = COLOR_W'(sg_prod >> COLOR_FRAC_BITS);
   end

   always_comb begin
      q_prod  = MUL_W'(v3d_ff) * MUL_W'(COLOR_ONE - sf3_ff);
      t_prod  = MUL_W'(v3d_ff) * MUL_W'(COLOR_ONE - sg3_ff);
      q_c     = COLOR_W'(q_prod >> COLOR_FRAC_BITS);
      t_c     = COLOR_W'(t_prod >> COLOR_FRAC_BITS);
      sec4_in = sec3_ff;
      if (grey3_ff) begin
         rgb4_in = '{red: v3d_ff, green: v3d_ff, blue: v3d_ff};
      end else begin
         case (sec4_in)
            SECTOR_0: rgb4_in = '{red: v3d_ff, green: t_c,    blue: p3_ff};
            SECTOR_1: rgb4_in = '{red: q_c,    green: v3d_ff, blue: p3_ff};
            SECTOR_2: rgb4_in = '{red: p3_ff,  green: v3d_ff, blue: t_c};
            SECTOR_3: rgb4_in = '{red: p3_ff,  green: q_c,    blue: v3d_ff};
            SECTOR_4: rgb4_in = '{red: t_c,    green: p3_ff,  blue: v3d_ff};
            default:  rgb4_in = '{red: v3d_ff, green: p3_ff,  blue: q_c};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         sec1_ff  <= sec_c;
         rem1_ff  <= rem1_in;
         s1_ff    <= s_c;
         v1d_ff   <= v_c;
         grey1_ff <= (s_c == '0);
      end
      if (ld2) begin
         sec2_ff  <= sec1_ff;
         s2_ff    <= s1_ff;
         v2d_ff   <= v1d_ff;
         grey2_ff <= grey1_ff;
         ff2_ff   <= ff2_in;
         p2_ff    <= p2_in;
      end
      if (ld3) begin
         sec3_ff  <= sec2_ff;
         v3d_ff   <= v2d_ff;
         grey3_ff <= grey2_ff;
         p3_ff    <= p2_ff;
         sf3_ff   <= sf3_in;
         sg3_ff   <= sg3_in;
      end
      if (ld4) begin
         rgb4_ff <= rgb4_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = rgb4_ff;

endmodule

>>> hdl/hsv2rgb_checker.sv
// Port-level checker for hsv_to_rgb_converter_unit, bound to the top level.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter_unit_defines.svh.
`include "hsv_to_rgb_converter_unit_defines.svh"

module hsv2rgb_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input hsv2rgb_pkg::hsv_pixel_type req_data,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input hsv2rgb_pkg::rgb_pixel_type rsp_data
);
   import hsv2rgb_pkg::*;

   `HSV2RGB_ASSERT_ALL(a_reset_empties, reset |=> !rsp_valid, "rsp_valid after reset")
   `HSV2RGB_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled rsp beat changed")
   `HSV2RGB_ASSERT(a_stall_only_full, req_stall |-> rsp_valid && rsp_stall, "req stalled with room in the pipe")
   `HSV2RGB_ASSERT(a_rsp_range, rsp_valid |-> rsp_data.red <= COLOR_ONE && rsp_data.green <= COLOR_ONE && rsp_data.blue <= COLOR_ONE, "rsp component above 1.0")

endmodule

bind hsv_to_rgb_converter_unit hsv2rgb_checker u_hsv2rgb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/sv/hsv_to_rgb_converter_unit_tb.sv
// Self-checking testbench for hsv_to_rgb_converter_unit: directed pixels, some with fixed expected values, then random
// pixel beats under varying idle/stall; all others are checked against an in-bench HSV to RGB model.
// Depends on hsv2rgb_pkg and the hsv_to_rgb_converter_unit RTL.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_unit_tb;
   import hsv2rgb_pkg::*;

   localparam int NUM_DIR      = 22;
   localparam int NUM_PHASES   = 5;
   localparam int PRESSURE_PH  = 4;
   localparam int HOLD_CYCLES  = 60;
   localparam int SETTLE_LIMIT = 16;

   typedef struct packed {
      hsv_pixel_type px;
      logic          known;
      rgb_pixel_type rgb;
   } pixel_row_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   hsv_pixel_type req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   rgb_pixel_type rsp_data;

   rgb_pixel_type expected_rgb_q [$];
   rgb_pixel_type want;
   hsv_pixel_type px;
   int            fail_count    = 0;
   int            send_idle_pct = 0;
   int            rsp_stall_pct = 0;
   int            hold_requests = 0;
   int            holds_done    = 0;

   int send_idle_by_phase [NUM_PHASES] = '{0, 66, 0, 15, 0};
   int rsp_stall_by_phase [NUM_PHASES] = '{0, 0, 66, 15, 0};
   int beats_by_phase     [NUM_PHASES] = '{440, 440, 440, 440, 100};

   // hue, saturation, value | expected known | red, green, blue
   pixel_row_type dir_rows [NUM_DIR] = '{
      '{'{0, 0, 0},            1'b1, '{0, 0, 0}},
      '{'{0, 0, 4096},         1'b1, '{4096, 4096, 4096}},
      '{'{32767, 0, 8191},     1'b1, '{4096, 4096, 4096}},
      '{'{0, 4096, 4096},      1'b1, '{4096, 0, 0}},
      '{'{7680, 4096, 4096},   1'b1, '{0, 4096, 0}},
      '{'{15360, 4096, 4096},  1'b1, '{0, 0, 4096}},
      '{'{23040, 4096, 4096},  1'b1, '{4096, 0, 0}},
      '{'{32767, 8191, 4096},  1'b1, '{4096, 0, 0}},
      '{'{0, 4096, 0},         1'b1, '{0, 0, 0}},
      '{'{3840, 4096, 4096},   1'b0, '{0, 0, 0}},
      '{'{3839, 4096, 4096},   1'b0, '{0, 0, 0}},
      '{'{11520, 2048, 4096},  1'b0, '{0, 0, 0}},
      '{'{19200, 2048, 3000},  1'b0, '{0, 0, 0}},
      '{'{23039, 4096, 4096},  1'b0, '{0, 0, 0}},
      '{'{1920, 2048, 4096},   1'b0, '{0, 0, 0}},
      '{'{5760, 1, 4096},      1'b0, '{0, 0, 0}},
      '{'{13440, 4095, 8191},  1'b0, '{0, 0, 0}},
      '{'{17280, 3000, 1234},  1'b0, '{0, 0, 0}},
      '{'{21120, 4096, 1},     1'b0, '{0, 0, 0}},
      '{'{23040, 2048, 2048},  1'b0, '{0, 0, 0}},
      '{'{21845, 2730, 5461},  1'b0, '{0, 0, 0}},
      '{'{10922, 5461, 2730},  1'b0, '{0, 0, 0}}
   };

   hsv_to_rgb_converter_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rgb_pixel_type convert_hsv_pixel(hsv_pixel_type pix);
      longint unsigned h, s, v, rem, ff, p, q, t;
      sector_type      sec;
      rgb_pixel_type   rgb;
      h = pix.hue;
      s = (pix.saturation > COLOR_ONE) ? COLOR_ONE : pix.saturation;
      v = (pix.value > COLOR_ONE) ? COLOR_ONE : pix.value;
      if (s == 0) begin
         rgb = '{COLOR_W'(v), COLOR_W'(v), COLOR_W'(v)};
      end else begin
         if (h >= HUE_FULL) h = 0;
         sec = sector_type'(SECTOR_W'(h / HUE_SECTOR));
         rem = h % HUE_SECTOR;
         ff  = (rem << COLOR_FRAC_BITS) / HUE_SECTOR;
         p   = (v * (COLOR_ONE - s)) >> COLOR_FRAC_BITS;
         q   = (v * (COLOR_ONE - ((s * ff) >> COLOR_FRAC_BITS))) >> COLOR_FRAC_BITS;
         t   = (v * (COLOR_ONE - ((s * (COLOR_ONE - ff)) >> COLOR_FRAC_BITS)))
               >> COLOR_FRAC_BITS;
         case (sec)
            SECTOR_0: rgb = '{COLOR_W'(v), COLOR_W'(t), COLOR_W'(p)};
            SECTOR_1: rgb = '{COLOR_W'(q), COLOR_W'(v), COLOR_W'(p)};
            SECTOR_2: rgb = '{COLOR_W'(p), COLOR_W'(v), COLOR_W'(t)};
            SECTOR_3: rgb = '{COLOR_W'(p), COLOR_W'(q), COLOR_W'(v)};
            SECTOR_4: rgb = '{COLOR_W'(t), COLOR_W'(p), COLOR_W'(v)};
            default:  rgb = '{COLOR_W'(v), COLOR_W'(p), COLOR_W'(q)};
         endcase
      end
      return rgb;
   endfunction

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_pixel(input hsv_pixel_type pix, input rgb_pixel_type rgb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rgb_q.push_back(rgb);
      @(negedge clock);
   endtask

   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_requests > holds_done) begin
            holds_done++;
            repeat (HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rgb_q.size() == 0) begin
            $display("%0t: rsp beat with nothing pending, got %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = expected_rgb_q.pop_front();
            if (rsp_data.red !== want.red) begin
               $display("%0t: red mismatch, expected %0d, got %0d",
                        $time, want.red, rsp_data.red);
               fail_count++;
            end
            if (rsp_data.green !== want.green) begin
               $display("%0t: green mismatch, expected %0d, got %0d",
                        $time, want.green, rsp_data.green);
               fail_count++;
            end
            if (rsp_data.blue !== want.blue) begin
               $display("%0t: blue mismatch, expected %0d, got %0d",
                        $time, want.blue, rsp_data.blue);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         send_pixel(dir_rows[i].px,
                    dir_rows[i].known ? dir_rows[i].rgb : convert_hsv_pixel(dir_rows[i].px));
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         send_idle_pct = send_idle_by_phase[ph];
         rsp_stall_pct = rsp_stall_by_phase[ph];
         if (ph == PRESSURE_PH) hold_requests++;
         for (int n = 0; n < beats_by_phase[ph]; n++) begin
            case ($urandom_range(9))
               0, 1:    px.hue = HUE_W'($urandom_range(32767));
               2:       px.hue = HUE_W'($urandom_range(6, 1) * HUE_SECTOR
                                        + $urandom_range(4) - 2);
               default: px.hue = HUE_W'($urandom_range(HUE_FULL - 1));
            endcase
            case ($urandom_range(9))
               0:       px.saturation = '0;
               1:       px.saturation = COLOR_W'($urandom_range(8191));
               2:       px.saturation = COLOR_ONE;
               default: px.saturation = COLOR_W'($urandom_range(COLOR_ONE, 1));
            endcase
            case ($urandom_range(9))
               0:       px.value = '0;
               1:       px.value = COLOR_W'($urandom_range(8191));
               2:       px.value = COLOR_ONE;
               default: px.value = COLOR_W'($urandom_range(COLOR_ONE));
            endcase
            send_pixel(px, convert_hsv_pixel(px));
         end
      end

      req_valid <= 1'b0;
      rsp_stall_pct = 0;
      while (expected_rgb_q.size() != 0) @(posedge clock);
      repeat (SETTLE_LIMIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("hsv_to_rgb_converter_unit test passed");
      end else begin
         $display("hsv_to_rgb_converter_unit test failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("hsv_to_rgb_converter_unit test failed");
      $finish;
   end

endmodule
